// ----- src/slgm_pkg.sv -----
// Package for the sparse LED grid mapper.
// Holds request codes, the sequencer states and the request, result and LED word types.
// Depends on nothing.
package slgm_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_POS  = 2'd1,
    ACT_IDX  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_CLEAR,
    ST_WALK,
    ST_DONE
  } state_t;

  localparam logic [7:0]  NO_VALUE = 8'hFF;
  localparam logic [15:0] NO_COORD = 16'hFFFF;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] led_number;
    logic       last_load;
  } req_t;

  typedef struct packed {
    logic       present;
    logic [7:0] led_at_cell;
    logic [7:0] coord_x;
    logic [7:0] coord_y;
    logic [8:0] grid_width;
    logic [8:0] grid_height;
    logic [7:0] led_total;
  } res_t;

  typedef struct packed {
    logic [7:0] sh_y;
    logic [7:0] sh_x;
    logic [7:0] raw_y;
    logic [7:0] raw_x;
  } led_word_t;

endpackage

// ----- src/slgm_ifs.sv -----
// Valid/ready channel interfaces for the request and result sides of the mapper.
// Depends on nothing.
interface slgm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] led_number;
  logic       last_load;

  modport source (output valid, action, pos_x, pos_y, led_number, last_load, input ready);
  modport sink (input valid, action, pos_x, pos_y, led_number, last_load, output ready);
endinterface

interface slgm_res_if;
  logic       valid;
  logic       ready;
  logic       present;
  logic [7:0] led_at_cell;
  logic [7:0] coord_x;
  logic [7:0] coord_y;
  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [7:0] led_total;

  modport source (output valid, present, led_at_cell, coord_x, coord_y, grid_width,
                  grid_height, led_total, input ready);
  modport sink (input valid, present, led_at_cell, coord_x, coord_y, grid_width,
                grid_height, led_total, output ready);
endinterface

// ----- src/slgm_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing.
module slgm_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/slgm_ctrl.sv -----
// Sequencer of the mapper: loads, queries, the cell clearing sweep and the build walk.
// Drives the LED and cell memories; depends on slgm_pkg.
module slgm_ctrl #(
  parameter int  LED_CAPACITY = 128,
  parameter int  GRID_COLUMNS = 16,
  parameter int  GRID_ROWS    = 16,
  localparam int CELLS        = GRID_COLUMNS * GRID_ROWS,
  localparam int LED_AW       = (LED_CAPACITY > 1) ? $clog2(LED_CAPACITY) : 1,
  localparam int CELL_AW      = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  slgm_pkg::req_t        req,
  input  logic                  slot_free,
  output logic                  res_push,
  output slgm_pkg::res_t        res,
  output logic                  led_we,
  output logic [LED_AW-1:0]     led_waddr,
  output slgm_pkg::led_word_t   led_wdata,
  output logic                  led_re,
  output logic [LED_AW-1:0]     led_raddr,
  input  slgm_pkg::led_word_t   led_rdata,
  output logic                  cell_we,
  output logic [CELL_AW-1:0]    cell_waddr,
  output logic [7:0]            cell_wdata,
  output logic                  cell_re,
  output logic [CELL_AW-1:0]    cell_raddr,
  input  logic [7:0]            cell_rdata
);

  localparam logic [7:0]         CAP       = 8'(LED_CAPACITY);
  localparam logic [8:0]         COLS      = 9'(GRID_COLUMNS);
  localparam logic [8:0]         ROWS      = 9'(GRID_ROWS);
  localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
    logic [15:0] lin;
    lin = ({8'd0, y} * 16'(GRID_COLUMNS)) + {8'd0, x};
    return CELL_AW'(lin);
  endfunction

  slgm_pkg::state_t   state_r, state_nxt;
  logic [7:0]         min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic [7:0]         max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  logic [7:0]         count_r, count_nxt;
  logic [8:0]         box_w_r, box_w_nxt, box_h_r, box_h_nxt;
  logic               built_r, built_nxt;
  logic               is_idx_r, is_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [CELL_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [7:0]         walk_idx_r, walk_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [LED_AW-1:0]  pend_idx_r, pend_idx_nxt;

  logic       acc;
  logic [7:0] base_min_x, base_min_y, base_max_x, base_max_y, base_cnt;
  logic       room;
  logic       pos_hit, idx_hit;
  logic       walk_more, walk_done;
  logic [7:0] ax, ay;
  logic       on_grid;

  assign acc        = req_valid && req_ready;
  assign base_min_x = built_r ? 8'hFF : min_x_r;
  assign base_min_y = built_r ? 8'hFF : min_y_r;
  assign base_max_x = built_r ? 8'h00 : max_x_r;
  assign base_max_y = built_r ? 8'h00 : max_y_r;
  assign base_cnt   = built_r ? 8'h00 : count_r;
  assign room       = base_cnt < CAP;
  assign pos_hit    = ({1'b0, req.pos_x} < box_w_r) && ({1'b0, req.pos_y} < box_h_r) &&
                      ({1'b0, req.pos_x} < COLS) && ({1'b0, req.pos_y} < ROWS);
  assign idx_hit    = built_r && (req.led_number < count_r);
  assign walk_more  = walk_idx_r < count_r;
  assign walk_done  = !walk_more && !pend_r;
  assign ax         = led_rdata.raw_x - min_x_r;
  assign ay         = led_rdata.raw_y - min_y_r;
  assign on_grid    = ({1'b0, ax} < COLS) && ({1'b0, ay} < ROWS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slgm_pkg::ST_IDLE: begin
        if (acc) begin
          case (req.action)
            slgm_pkg::ACT_LOAD: begin
              if (req.last_load) begin
                state_nxt = slgm_pkg::ST_CLEAR;
              end
            end
            slgm_pkg::ACT_POS, slgm_pkg::ACT_IDX: state_nxt = slgm_pkg::ST_QUERY;
            default: state_nxt = slgm_pkg::ST_IDLE;
          endcase
        end
      end
      slgm_pkg::ST_QUERY: begin
        if (slot_free) begin
          state_nxt = slgm_pkg::ST_IDLE;
        end
      end
      slgm_pkg::ST_CLEAR: begin
        if (clr_idx_r == CELL_LAST) begin
          state_nxt = slgm_pkg::ST_WALK;
        end
      end
      slgm_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = slgm_pkg::ST_DONE;
        end
      end
      slgm_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = slgm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slgm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = (state_r == slgm_pkg::ST_IDLE);
    led_we     = 1'b0;
    led_waddr  = base_cnt[LED_AW-1:0];
    led_wdata  = {slgm_pkg::NO_COORD, req.pos_y, req.pos_x};
    led_re     = 1'b0;
    led_raddr  = req.led_number[LED_AW-1:0];
    cell_we    = 1'b0;
    cell_waddr = clr_idx_r;
    cell_wdata = slgm_pkg::NO_VALUE;
    cell_re    = 1'b0;
    cell_raddr = cell_addr(req.pos_x, req.pos_y);
    res_push   = 1'b0;
    res        = '{present: 1'b0, led_at_cell: slgm_pkg::NO_VALUE,
                   coord_x: slgm_pkg::NO_VALUE, coord_y: slgm_pkg::NO_VALUE,
                   grid_width: box_w_r, grid_height: box_h_r, led_total: count_r};
    case (state_r)
      slgm_pkg::ST_IDLE: begin
        if (acc) begin
          case (req.action)
            slgm_pkg::ACT_LOAD: led_we  = room;
            slgm_pkg::ACT_POS:  cell_re = pos_hit;
            slgm_pkg::ACT_IDX:  led_re  = idx_hit;
            default: led_we = 1'b0;
          endcase
        end
      end
      slgm_pkg::ST_QUERY: begin
        res_push = slot_free;
        if (hit_r) begin
          if (is_idx_r) begin
            res.coord_x = led_rdata.sh_x;
            res.coord_y = led_rdata.sh_y;
          end else begin
            res.led_at_cell = cell_rdata;
            res.present     = (cell_rdata != slgm_pkg::NO_VALUE);
          end
        end
      end
      slgm_pkg::ST_CLEAR: begin
        cell_we = 1'b1;
      end
      slgm_pkg::ST_WALK: begin
        led_re    = walk_more;
        led_raddr = walk_idx_r[LED_AW-1:0];
        if (pend_r) begin
          led_we     = 1'b1;
          led_waddr  = pend_idx_r;
          led_wdata  = {on_grid ? {ay, ax} : slgm_pkg::NO_COORD,
                        led_rdata.raw_y, led_rdata.raw_x};
          cell_we    = on_grid;
          cell_waddr = cell_addr(ax, ay);
          cell_wdata = 8'(pend_idx_r);
        end
      end
      slgm_pkg::ST_DONE: begin
        res_push = slot_free;
      end
      default: res_push = 1'b0;
    endcase
  end

  always_comb begin
    min_x_nxt    = min_x_r;
    min_y_nxt    = min_y_r;
    max_x_nxt    = max_x_r;
    max_y_nxt    = max_y_r;
    count_nxt    = count_r;
    box_w_nxt    = box_w_r;
    box_h_nxt    = box_h_r;
    built_nxt    = built_r;
    is_idx_nxt   = is_idx_r;
    hit_nxt      = hit_r;
    clr_idx_nxt  = clr_idx_r;
    walk_idx_nxt = walk_idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    case (state_r)
      slgm_pkg::ST_IDLE: begin
        if (acc) begin
          case (req.action)
            slgm_pkg::ACT_LOAD: begin
              min_x_nxt = base_min_x;
              min_y_nxt = base_min_y;
              max_x_nxt = base_max_x;
              max_y_nxt = base_max_y;
              count_nxt = base_cnt;
              if (built_r) begin
                built_nxt = 1'b0;
                box_w_nxt = '0;
                box_h_nxt = '0;
              end
              if (room) begin
                if (req.pos_x < base_min_x) min_x_nxt = req.pos_x;
                if (req.pos_y < base_min_y) min_y_nxt = req.pos_y;
                if (req.pos_x > base_max_x) max_x_nxt = req.pos_x;
                if (req.pos_y > base_max_y) max_y_nxt = req.pos_y;
                count_nxt = base_cnt + 8'd1;
              end
              clr_idx_nxt  = '0;
              walk_idx_nxt = '0;
              pend_nxt     = 1'b0;
            end
            slgm_pkg::ACT_POS: begin
              is_idx_nxt = 1'b0;
              hit_nxt    = pos_hit;
            end
            slgm_pkg::ACT_IDX: begin
              is_idx_nxt = 1'b1;
              hit_nxt    = idx_hit;
            end
            default: hit_nxt = hit_r;
          endcase
        end
      end
      slgm_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CELL_AW'(1);
      end
      slgm_pkg::ST_WALK: begin
        pend_nxt = walk_more;
        if (walk_more) begin
          walk_idx_nxt = walk_idx_r + 8'd1;
          pend_idx_nxt = walk_idx_r[LED_AW-1:0];
        end
        if (walk_done) begin
          built_nxt = 1'b1;
          if (count_r == 8'd0) begin
            box_w_nxt = '0;
            box_h_nxt = '0;
          end else begin
            box_w_nxt = {1'b0, max_x_r} - {1'b0, min_x_r} + 9'd1;
            box_h_nxt = {1'b0, max_y_r} - {1'b0, min_y_r} + 9'd1;
          end
        end
      end
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= slgm_pkg::ST_IDLE;
      min_x_r    <= 8'hFF;
      min_y_r    <= 8'hFF;
      max_x_r    <= 8'h00;
      max_y_r    <= 8'h00;
      count_r    <= 8'h00;
      box_w_r    <= '0;
      box_h_r    <= '0;
      built_r    <= 1'b0;
      is_idx_r   <= 1'b0;
      hit_r      <= 1'b0;
      clr_idx_r  <= '0;
      walk_idx_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      min_x_r    <= min_x_nxt;
      min_y_r    <= min_y_nxt;
      max_x_r    <= max_x_nxt;
      max_y_r    <= max_y_nxt;
      count_r    <= count_nxt;
      box_w_r    <= box_w_nxt;
      box_h_r    <= box_h_nxt;
      built_r    <= built_nxt;
      is_idx_r   <= is_idx_nxt;
      hit_r      <= hit_nxt;
      clr_idx_r  <= clr_idx_nxt;
      walk_idx_r <= walk_idx_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("LED count has passed the capacity.");

  a_box_unbuilt: assert property (@(posedge clk) disable iff (!rst_n)
    !built_r |-> (box_w_r == 9'd0 && box_h_r == 9'd0))
    else $error("Box size is non-zero without a completed build.");

  a_built_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(state_r) == slgm_pkg::ST_WALK)
    else $error("Build flag set outside the table walk.");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> 8'(pend_idx_r) < count_r)
    else $error("Walk writes back an LED beyond the loaded count.");

  a_cell_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!cell_we || cell_waddr <= CELL_LAST) && (!cell_re || cell_raddr <= CELL_LAST))
    else $error("Cell memory address beyond the grid.");
`endif

endmodule

// ----- src/sparse_led_grid_mapper.sv -----
// Top level of the sparse LED grid mapper: sequencer, LED and cell memories, result register.
// Depends on slgm_pkg, slgm_ifs, slgm_ram and slgm_ctrl.
//
// Channel  Direction  Handshake    Payload
// in_req   in         valid/ready  action, pos_x, pos_y, led_number, last_load
// out_res  out        valid/ready  present, led_at_cell, coord_x, coord_y, grid_width,
//                                  grid_height, led_total
//
// A plain load gives no result; a position or index query does a registered memory read
// and then pushes its result. A last load runs the request, a clearing sweep of the cell
// memory at one cell a cycle, a walk over the LED memory at one LED a cycle and its drain,
// and the result. Reset is synchronous; the memories keep their contents and every build
// clears the cell memory. Requests are taken only while the sequencer is idle; a finished
// result waits there while the output is full.
module sparse_led_grid_mapper #(
  parameter int LED_CAPACITY = 128,
  parameter int GRID_COLUMNS = 16,
  parameter int GRID_ROWS    = 16
) (
  input logic        clk,
  input logic        rst_n,
  slgm_req_if.sink   in_req,
  slgm_res_if.source out_res
);

  localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
  localparam int LED_AW  = (LED_CAPACITY > 1) ? $clog2(LED_CAPACITY) : 1;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  slgm_pkg::req_t      req;
  slgm_pkg::res_t      res;
  slgm_pkg::res_t      res_r;
  logic                out_valid_r;
  logic                slot_free;
  logic                res_push;
  logic                led_we, led_re;
  logic [LED_AW-1:0]   led_waddr, led_raddr;
  slgm_pkg::led_word_t led_wdata, led_rdata;
  logic                cell_we, cell_re;
  logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
  logic [7:0]          cell_wdata, cell_rdata;

  assign req = '{action: in_req.action, pos_x: in_req.pos_x, pos_y: in_req.pos_y,
                 led_number: in_req.led_number, last_load: in_req.last_load};
  assign slot_free = !out_valid_r || out_res.ready;

  slgm_ctrl #(
    .LED_CAPACITY(LED_CAPACITY),
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req       (req),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res       (res),
    .led_we    (led_we),
    .led_waddr (led_waddr),
    .led_wdata (led_wdata),
    .led_re    (led_re),
    .led_raddr (led_raddr),
    .led_rdata (led_rdata),
    .cell_we   (cell_we),
    .cell_waddr(cell_waddr),
    .cell_wdata(cell_wdata),
    .cell_re   (cell_re),
    .cell_raddr(cell_raddr),
    .cell_rdata(cell_rdata)
  );

  slgm_ram #(
    .DEPTH(LED_CAPACITY),
    .AW   (LED_AW),
    .DW   ($bits(slgm_pkg::led_word_t))
  ) u_led_ram (
    .clk  (clk),
    .we   (led_we),
    .waddr(led_waddr),
    .wdata(led_wdata),
    .re   (led_re),
    .raddr(led_raddr),
    .rdata(led_rdata)
  );

  slgm_ram #(
    .DEPTH(CELLS),
    .AW   (CELL_AW),
    .DW   (8)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .re   (cell_re),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.present     = res_r.present;
  assign out_res.led_at_cell = res_r.led_at_cell;
  assign out_res.coord_x     = res_r.coord_x;
  assign out_res.coord_y     = res_r.coord_y;
  assign out_res.grid_width  = res_r.grid_width;
  assign out_res.grid_height = res_r.grid_height;
  assign out_res.led_total   = res_r.led_total;

endmodule

// ----- dv/grid_map_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sparse LED grid mapper: watches both channels, predicts every answer
// and compares each one field by field. Depends on slgm_pkg and the channel interfaces.
module grid_map_checker #(
  parameter int LED_CAPACITY = 128,
  parameter int GRID_COLUMNS = 16,
  parameter int GRID_ROWS    = 16
) (
  input  logic clk,
  input  logic rst_n,
  slgm_req_if  req,
  slgm_res_if  res,
  output int   fail_count,
  output int   pending
);

  localparam int CELLS = GRID_COLUMNS * GRID_ROWS;

  logic [15:0]    raw_pos  [LED_CAPACITY];
  logic [15:0]    grid_pos [LED_CAPACITY];
  bit             occupied [CELLS];
  logic [7:0]     owner    [CELLS];
  logic [7:0]     lo_x, lo_y, hi_x, hi_y;
  logic [7:0]     led_count;
  logic [8:0]     box_w, box_h;
  bit             tables_valid;
  slgm_pkg::res_t due_answers [$];

  function automatic void start_string();
    lo_x = slgm_pkg::NO_VALUE;
    lo_y = slgm_pkg::NO_VALUE;
    hi_x = '0;
    hi_y = '0;
    led_count = '0;
    box_w = '0;
    box_h = '0;
    tables_valid = 1'b0;
  endfunction

  function automatic void clear_cells();
    foreach (occupied[c]) begin
      occupied[c] = 1'b0;
      owner[c] = slgm_pkg::NO_VALUE;
    end
  endfunction

  function automatic void build_grid();
    logic [7:0] ax, ay;
    int cell_no;
    clear_cells();
    tables_valid = 1'b1;
    if (led_count == 0) begin
      box_w = '0;
      box_h = '0;
      return;
    end
    box_w = {1'b0, hi_x} - {1'b0, lo_x} + 9'd1;
    box_h = {1'b0, hi_y} - {1'b0, lo_y} + 9'd1;
    for (int i = 0; i < led_count; i++) begin
      ax = raw_pos[i][7:0] - lo_x;
      ay = raw_pos[i][15:8] - lo_y;
      if (ax >= GRID_COLUMNS || ay >= GRID_ROWS) begin
        grid_pos[i] = slgm_pkg::NO_COORD;
      end else begin
        cell_no = ay * GRID_COLUMNS + ax;
        occupied[cell_no] = 1'b1;
        owner[cell_no] = 8'(i);
        grid_pos[i] = {ay, ax};
      end
    end
  endfunction

  // Returns 1 when the request produces an answer.
  function automatic bit mapper_answer(input slgm_pkg::req_t r, output slgm_pkg::res_t a);
    int cell_no;
    a.present = 1'b0;
    a.led_at_cell = slgm_pkg::NO_VALUE;
    a.coord_x = slgm_pkg::NO_VALUE;
    a.coord_y = slgm_pkg::NO_VALUE;
    case (r.action)
      slgm_pkg::ACT_LOAD: begin
        if (tables_valid) start_string();
        if (led_count < LED_CAPACITY) begin
          raw_pos[led_count] = {r.pos_y, r.pos_x};
          if (r.pos_x < lo_x) lo_x = r.pos_x;
          if (r.pos_y < lo_y) lo_y = r.pos_y;
          if (r.pos_x > hi_x) hi_x = r.pos_x;
          if (r.pos_y > hi_y) hi_y = r.pos_y;
          led_count = led_count + 8'd1;
        end
        if (!r.last_load) return 1'b0;
        build_grid();
      end
      slgm_pkg::ACT_POS: begin
        if (r.pos_x < box_w && r.pos_y < box_h &&
            r.pos_x < GRID_COLUMNS && r.pos_y < GRID_ROWS) begin
          cell_no = r.pos_y * GRID_COLUMNS + r.pos_x;
          a.present = occupied[cell_no];
          a.led_at_cell = owner[cell_no];
        end
      end
      slgm_pkg::ACT_IDX: begin
        if (tables_valid && r.led_number < led_count && r.led_number < LED_CAPACITY) begin
          a.coord_x = grid_pos[r.led_number][7:0];
          a.coord_y = grid_pos[r.led_number][15:8];
        end
      end
      default: return 1'b0;
    endcase
    a.grid_width = box_w;
    a.grid_height = box_h;
    a.led_total = led_count;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    slgm_pkg::req_t r;
    slgm_pkg::res_t a;
    if (!rst_n) begin
      clear_cells();
      start_string();
      due_answers.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (due_answers.size() == 0) begin
          fail_count++;
          $display("%0t: result mismatch, expected none, got present=%0d led=%0d x=%0d y=%0d",
                   $time, res.present, res.led_at_cell, res.coord_x, res.coord_y);
        end else begin
          a = due_answers.pop_front();
          check_field("present", 9'(a.present), 9'(res.present));
          check_field("led_at_cell", 9'(a.led_at_cell), 9'(res.led_at_cell));
          check_field("coord_x", 9'(a.coord_x), 9'(res.coord_x));
          check_field("coord_y", 9'(a.coord_y), 9'(res.coord_y));
          check_field("grid_width", a.grid_width, res.grid_width);
          check_field("grid_height", a.grid_height, res.grid_height);
          check_field("led_total", 9'(a.led_total), 9'(res.led_total));
        end
      end
      if (req.valid && req.ready) begin
        r.action = req.action;
        r.pos_x = req.pos_x;
        r.pos_y = req.pos_y;
        r.led_number = req.led_number;
        r.last_load = req.last_load;
        if (mapper_answer(r, a)) due_answers.push_back(a);
      end
    end
    pending = due_answers.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the sparse LED grid mapper testbench: clock, reset, request stimulus and result
// back-pressure. Depends on slgm_pkg, the channel interfaces, the block and grid_map_checker.
module tb;

  localparam int          CLK_PERIOD     = 10;
  localparam int          LED_CAPACITY   = 128;
  localparam int          GRID_COLUMNS   = 16;
  localparam int          GRID_ROWS      = 16;
  localparam int          ITEMS          = 1150;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 400;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   quiet_cycles;
  bit   burst;
  bit   hold_off_req;

  slgm_req_if req_ch ();
  slgm_res_if res_ch ();

  sparse_led_grid_mapper #(
    .LED_CAPACITY(LED_CAPACITY),
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_res(res_ch)
  );

  grid_map_checker #(
    .LED_CAPACITY(LED_CAPACITY),
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_ch),
    .res       (res_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic slgm_pkg::req_t make_req(input logic [1:0] act, input logic [7:0] x,
                                              input logic [7:0] y, input logic [7:0] n,
                                              input logic l);
    slgm_pkg::req_t r;
    r.action = act;
    r.pos_x = x;
    r.pos_y = y;
    r.led_number = n;
    r.last_load = l;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A query or an unused request, aimed mostly at cells and LEDs that exist.
  function automatic slgm_pkg::req_t random_query(input int leds);
    int k;
    logic [7:0] x, y, n;
    k = $urandom_range(0, 99);
    x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
    y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
    n = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                    : 8'($urandom_range(0, (leds + 2 > 255) ? 255 : leds + 2));
    if (k < 45) return make_req(slgm_pkg::ACT_POS, x, y, 8'($urandom), 1'($urandom));
    if (k < 93) return make_req(slgm_pkg::ACT_IDX, 8'($urandom), 8'($urandom), n,
                                1'($urandom));
    return make_req(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  task automatic send_request(input slgm_pkg::req_t r);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.pos_x <= r.pos_x;
    req_ch.pos_y <= r.pos_y;
    req_ch.led_number <= r.led_number;
    req_ch.last_load <= r.last_load;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // One string of LEDs: loads with the odd query between them, then a run of queries.
  task automatic run_string(input int set_no);
    int n, q, mode, base_x, base_y, span;
    bit closes;
    logic [7:0] x, y;
    mode = $urandom_range(0, 9);
    base_x = $urandom_range(0, 230);
    base_y = $urandom_range(0, 230);
    span = (mode < 7) ? 15 : 24;
    n = $urandom_range(0, 19);
    if (set_no == 2 || n == 0) n = 128 + $urandom_range(0, 10);
    else if (n < 3) n = $urandom_range(25, 60);
    else n = $urandom_range(1, 24);
    closes = ($urandom_range(0, 19) != 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(random_query(i));
      if (mode == 9 || $urandom_range(0, 11) == 0) begin
        x = 8'($urandom);
        y = 8'($urandom);
      end else begin
        x = 8'(base_x + $urandom_range(0, span));
        y = 8'(base_y + $urandom_range(0, span));
      end
      send_request(make_req(slgm_pkg::ACT_LOAD, x, y, 8'($urandom), closes && i == n - 1));
    end
    if (set_no == 5) begin
      hold_off_req = 1'b1;
      burst = 1'b1;
      q = 24;
    end else begin
      q = $urandom_range(4, 30);
    end
    repeat (q) send_request(random_query(n));
    burst = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      int k;
      k = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (k < 55) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (k < 65) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else if (k < 95) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = slgm_pkg::ACT_LOAD;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.led_number = '0;
    req_ch.last_load = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Queries before any build, then an unused request.
    send_request(make_req(slgm_pkg::ACT_POS, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(ACT_UNUSED, 8'd255, 8'd255, 8'd255, 1'b1));
    // A single LED, then an index just out of range.
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd5, 8'd7, 8'd0, 1'b1));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd1, 1'b0));
    // The widest box: the second LED lies outside the grid.
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd0, 8'd0, 8'd255, 1'b0));
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd255, 8'd255, 8'd255, 1'b1));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd1, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd15, 8'd15, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd16, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd255, 8'd255, 8'd0, 1'b0));
    // Two LEDs in one cell: the later one owns it.
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd3, 8'd3, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd3, 8'd3, 8'd0, 1'b1));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd0, 1'b0));
    // Queries in the middle of a fresh load.
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd10, 8'd10, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(slgm_pkg::ACT_LOAD, 8'd11, 8'd12, 8'd0, 1'b1));
    send_request(make_req(slgm_pkg::ACT_IDX, 8'd0, 8'd0, 8'd255, 1'b0));
    send_request(make_req(slgm_pkg::ACT_POS, 8'd1, 8'd2, 8'd0, 1'b0));

    for (int set_no = 0; items_sent < ITEMS; set_no++) run_string(set_no);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
